// ===== rtl/pcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types, constants and CRC-32 helpers of the PNG chunk deframer.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int NUM_KNOWN_TYPES = 9;
  localparam int TABLE_NAMES     = 9;
  localparam int SLOT_LIMIT      = (NUM_KNOWN_TYPES < TABLE_NAMES) ? NUM_KNOWN_TYPES
                                                                   : TABLE_NAMES;
  localparam int SLOT_W          = (NUM_KNOWN_TYPES > 1) ? $clog2(NUM_KNOWN_TYPES) : 1;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [15:0] SAT16    = 16'hFFFF;
  localparam logic [15:0] MIN_HUNT = 16'd8;

  localparam logic [31:0] TYPE_NAMES [TABLE_NAMES] = '{
    "NULL", "IHDR", "PLTE", "IDAT", "IEND", "sRGB", "gAMA", "pHYs", "tEXt"
  };

  typedef enum logic [1:0] {
    MODE_HUNT    = 2'd0,
    MODE_DATA    = 2'd1,
    MODE_TRAILER = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic [31:0] computed_crc;
    logic [3:0]  type_slot;
    logic [15:0] occurrence;
    logic [15:0] skipped_bytes;
  } out_word_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } in_hold_t;

  typedef struct packed {
    logic      load;
    out_word_t word;
  } out_load_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  // CRC of four bytes from the initial value, first byte in the top lane
  function automatic logic [31:0] crc_word(input logic [31:0] w);
    logic [31:0] r;
    r = CRC_INIT;
    for (int k = 3; k >= 0; k--) begin
      r = crc_byte(r, w[8*k +: 8]);
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic [3:0] lookup_slot(input logic [31:0] t);
    logic [3:0] s;
    s = 4'd0;
    for (int i = SLOT_LIMIT - 1; i >= 0; i--) begin
      if (TYPE_NAMES[i] == t) begin
        s = 4'(i);
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/pcd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd channel interfaces
// Byte input, chunk result and configuration write channels.
// ----------------------------------------------------------------------------
interface pcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface pcd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] chunk_type;
  logic [31:0] chunk_length;
  logic [31:0] computed_crc;
  logic [3:0]  type_slot;
  logic [15:0] occurrence;
  logic [15:0] skipped_bytes;
  modport source (output valid, chunk_type, chunk_length, computed_crc, type_slot,
                  occurrence, skipped_bytes, input ready);
  modport sink   (input valid, chunk_type, chunk_length, computed_crc, type_slot,
                  occurrence, skipped_bytes, output ready);
endinterface

interface pcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_occurrence_number;
  modport source (output valid, first_occurrence_number, input ready);
  modport sink   (input valid, first_occurrence_number, output ready);
endinterface

// ===== rtl/pcd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_in_stage
// Input register: holds one stream word until the parser takes it.
// ----------------------------------------------------------------------------
module pcd_in_stage (
  input  logic            clk,
  input  logic            rst,
  pcd_in_if.sink          stream,
  output pcd_pkg::in_hold_t held,
  input  logic            take
);
  import pcd_pkg::*;

  logic     valid;
  in_word_t word;
  logic     accept;

  assign stream.ready = !valid || take;
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= '{in_byte: stream.in_byte, last_byte: stream.last_byte};
    end
  end

  assign held = '{valid: valid, word: word};

endmodule

// ===== rtl/pcd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_out_stage
// Result register: holds one chunk word until the sink takes it.
// ----------------------------------------------------------------------------
module pcd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  pcd_pkg::out_load_t result,
  output logic               can_load,
  pcd_out_if.source          chunks
);
  import pcd_pkg::*;

  logic      valid;
  out_word_t word;

  assign can_load = !valid || chunks.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (result.load) begin
      valid <= 1'b1;
    end else if (chunks.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.load) begin
      word <= result.word;
    end
  end

  assign chunks.valid         = valid;
  assign chunks.chunk_type    = word.chunk_type;
  assign chunks.chunk_length  = word.chunk_length;
  assign chunks.computed_crc  = word.computed_crc;
  assign chunks.type_slot     = word.type_slot;
  assign chunks.occurrence    = word.occurrence;
  assign chunks.skipped_bytes = word.skipped_bytes;

endmodule

// ===== rtl/pcd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_parser
// Chunk hunt, CRC-32 over type and data, trailer skip and per-type counters.
// ----------------------------------------------------------------------------
module pcd_parser (
  input  logic               clk,
  input  logic               rst,
  input  pcd_pkg::in_hold_t  held,
  output logic               take,
  output pcd_pkg::out_load_t result,
  input  logic               can_load,
  pcd_cfg_if.sink            cfg
);
  import pcd_pkg::*;

  logic [63:0] recent_bytes,   recent_bytes_next;
  mode_t       parse_mode,     parse_mode_next;
  logic [15:0] hunt_count,     hunt_count_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [31:0] crc_register,   crc_register_next;
  logic [31:0] latched_type,   latched_type_next;
  logic [31:0] latched_length, latched_length_next;
  logic [1:0]  trailer_count,  trailer_count_next;
  logic [15:0] type_counters [NUM_KNOWN_TYPES];

  logic [7:0]  b;
  logic [63:0] recent_shift;
  logic [15:0] hunt_inc;
  logic        found;
  logic [15:0] skipped;
  logic [31:0] type_crc;
  logic [31:0] data_crc;
  logic [31:0] remaining_dec;
  logic        is_hunt;
  logic        emit;
  out_word_t   emit_word;
  logic [3:0]  slot;
  logic [15:0] slot_count;

  assign cfg.ready = 1'b1;
  assign b         = held.word.in_byte;

  // decode
  always_comb begin
    recent_shift  = {recent_bytes[55:0], b};
    hunt_inc      = (hunt_count != SAT16) ? hunt_count + 16'd1 : hunt_count;
    found         = (hunt_inc >= MIN_HUNT) &&
                    is_letter(recent_shift[31:24]) && is_letter(recent_shift[23:16]) &&
                    is_letter(recent_shift[15:8])  && is_letter(recent_shift[7:0]);
    skipped       = (hunt_inc == SAT16) ? SAT16 : hunt_inc - MIN_HUNT;
    type_crc      = crc_word(recent_shift[31:0]);
    data_crc      = crc_byte(crc_register, b);
    remaining_dec = data_remaining - 32'd1;
    is_hunt       = (parse_mode != MODE_DATA) && (parse_mode != MODE_TRAILER);

    case (parse_mode)
      MODE_DATA:    emit = (remaining_dec == 32'd0);
      MODE_TRAILER: emit = 1'b0;
      default:      emit = found && (recent_shift[63:32] == 32'd0);
    endcase

    emit_word.chunk_type    = is_hunt ? recent_shift[31:0]  : latched_type;
    emit_word.chunk_length  = is_hunt ? recent_shift[63:32] : latched_length;
    emit_word.computed_crc  = ~(is_hunt ? type_crc : data_crc);
    slot                    = lookup_slot(emit_word.chunk_type);
    slot_count              = type_counters[slot[SLOT_W-1:0]];
    emit_word.type_slot     = slot;
    emit_word.occurrence    = slot_count;
    emit_word.skipped_bytes = is_hunt ? skipped : hunt_count;
  end

  // outputs
  always_comb begin
    take        = held.valid && (!emit || can_load);
    result.load = take && emit;
    result.word = emit_word;
  end

  // next state
  always_comb begin
    recent_bytes_next   = recent_bytes;
    parse_mode_next     = parse_mode;
    hunt_count_next     = hunt_count;
    data_remaining_next = data_remaining;
    crc_register_next   = crc_register;
    latched_type_next   = latched_type;
    latched_length_next = latched_length;
    trailer_count_next  = trailer_count;

    case (parse_mode)
      MODE_DATA: begin
        crc_register_next   = data_crc;
        data_remaining_next = remaining_dec;
        if (emit) begin
          parse_mode_next    = MODE_TRAILER;
          trailer_count_next = 2'd0;
        end
      end
      MODE_TRAILER: begin
        if (trailer_count == 2'd3) begin
          recent_bytes_next   = 64'd0;
          hunt_count_next     = 16'd0;
          parse_mode_next     = MODE_HUNT;
          trailer_count_next  = 2'd0;
          data_remaining_next = 32'd0;
        end else begin
          trailer_count_next = trailer_count + 2'd1;
        end
      end
      default: begin
        recent_bytes_next = recent_shift;
        hunt_count_next   = hunt_inc;
        if (found) begin
          latched_type_next   = recent_shift[31:0];
          latched_length_next = recent_shift[63:32];
          crc_register_next   = type_crc;
          data_remaining_next = recent_shift[63:32];
          hunt_count_next     = skipped;
          recent_bytes_next   = 64'd0;
          if (emit) begin
            parse_mode_next    = MODE_TRAILER;
            trailer_count_next = 2'd0;
          end else begin
            parse_mode_next = MODE_DATA;
          end
        end
      end
    endcase

    if (held.word.last_byte) begin
      recent_bytes_next   = 64'd0;
      hunt_count_next     = 16'd0;
      parse_mode_next     = MODE_HUNT;
      trailer_count_next  = 2'd0;
      data_remaining_next = 32'd0;
      crc_register_next   = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes   <= 64'd0;
      parse_mode     <= MODE_HUNT;
      hunt_count     <= 16'd0;
      data_remaining <= 32'd0;
      crc_register   <= CRC_INIT;
      latched_type   <= 32'd0;
      latched_length <= 32'd0;
      trailer_count  <= 2'd0;
    end else if (take) begin
      recent_bytes   <= recent_bytes_next;
      parse_mode     <= parse_mode_next;
      hunt_count     <= hunt_count_next;
      data_remaining <= data_remaining_next;
      crc_register   <= crc_register_next;
      latched_type   <= latched_type_next;
      latched_length <= latched_length_next;
      trailer_count  <= trailer_count_next;
    end
  end

  // reload all counters on a register write, advance the emitted slot
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KNOWN_TYPES; i++) begin
        type_counters[i] <= 16'd0;
      end
    end else if (cfg.valid) begin
      for (int i = 0; i < NUM_KNOWN_TYPES; i++) begin
        type_counters[i] <= cfg.first_occurrence_number;
      end
    end else if (result.load && (slot_count != SAT16)) begin
      type_counters[slot[SLOT_W-1:0]] <= slot_count + 16'd1;
    end
  end

endmodule

// ===== rtl/png_chunk_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_deframer
// Byte-serial PNG chunk deframer with CRC-32 and per-type occurrence counts.
//
//   port     dir   word
//   stream   in    in_byte, last_byte
//   chunks   out   chunk_type, chunk_length, computed_crc, type_slot,
//                  occurrence, skipped_bytes
//   cfg      in    first_occurrence_number
//
// One byte per cycle sustained while no completing byte meets a held result; a
// byte reaches the parser in the cycle after it is taken, and a result shows on
// chunks the cycle after that byte is parsed. The combinational byte CRC step and
// type match in the parser set that rate. A held result stalls only bytes that would
// complete another chunk; until then the input register keeps taking bytes.
// Reset: synchronous rst clears the handshake and parser state; cfg is always ready.
// ----------------------------------------------------------------------------
module png_chunk_deframer (
  input  logic      clk,
  input  logic      rst,
  pcd_in_if.sink    stream,
  pcd_out_if.source chunks,
  pcd_cfg_if.sink   cfg
);
  import pcd_pkg::*;

  in_hold_t  held;
  logic      take;
  out_load_t result;
  logic      can_load;

  pcd_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .held   (held),
    .take   (take)
  );

  pcd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .held     (held),
    .take     (take),
    .result   (result),
    .can_load (can_load),
    .cfg      (cfg)
  );

  pcd_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .can_load (can_load),
    .chunks   (chunks)
  );

endmodule
